// ===== sv/mkte_pkg.sv =====
`timescale 1ns / 1ps

package mkte_pkg;

  localparam int unsigned NUM_KEYS = 13;

  // keypad scan positions
  localparam logic [3:0] KEY_ONE  = 4'd0;
  localparam logic [3:0] KEY_BACK = 4'd3;
  localparam logic [3:0] KEY_NINE = 4'd9;
  localparam logic [3:0] KEY_STAR = 4'd10;
  localparam logic [3:0] KEY_ZERO = 4'd11;
  localparam logic [3:0] KEY_HASH = 4'd12;

  // phase codes
  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_FIRSTHOLD = 3'd1;
  localparam logic [2:0] PH_WINDOW    = 3'd2;
  localparam logic [2:0] PH_TAPHOLD   = 3'd3;
  localparam logic [2:0] PH_BACKHOLD  = 3'd4;

  // action codes on the result channel
  localparam logic ACT_CHAR  = 1'b0;
  localparam logic ACT_BLANK = 1'b1;

  localparam logic [6:0]  BLANK_CODE       = 7'd32;
  localparam logic [15:0] WINDOW_TICKS_RST = 16'd750;

  typedef logic [6:0] char_t;

  // Character for a key and tap count. Keys 2..8: three letters then digit.
  // Key 9: Y, Z, '9', backslash. Star, zero and hash are fixed.
  function automatic char_t char_for(input logic [3:0] k, input logic [1:0] z);
    char_t base;
    char_t digit;
    char_t res;
    base  = 7'd0;
    digit = 7'd0;
    case (k)
      4'd1:    begin base = 7'd68; digit = 7'd50; end
      4'd2:    begin base = 7'd71; digit = 7'd51; end
      4'd4:    begin base = 7'd74; digit = 7'd52; end
      4'd5:    begin base = 7'd77; digit = 7'd53; end
      4'd6:    begin base = 7'd80; digit = 7'd54; end
      4'd7:    begin base = 7'd83; digit = 7'd55; end
      4'd8:    begin base = 7'd86; digit = 7'd56; end
      4'd9:    begin base = 7'd89; digit = 7'd57; end
      4'd10:   digit = 7'd42;
      4'd11:   digit = 7'd48;
      4'd12:   digit = 7'd35;
      default: digit = 7'd0;
    endcase
    if (k == KEY_STAR || k == KEY_ZERO || k == KEY_HASH) begin
      res = digit;
    end else if (k == KEY_NINE) begin
      res = (z == 2'd2) ? digit : base + {5'd0, z};
    end else if (k == KEY_ONE || k == KEY_BACK || k > KEY_HASH) begin
      res = 7'd0;
    end else begin
      res = (z == 2'd3) ? digit : base + {5'd0, z};
    end
    return res;
  endfunction

endpackage

// ===== sv/multitap_keypad_text_entry.sv =====
`timescale 1ns / 1ps

// Multi-tap keypad text entry.
//
// Input channel (in_valid/in_ready, key_lines): one transfer per millisecond
// tick, carrying the 13 key lines in scan order 1,2,3,back,4,5,6,7,8,9,*,0,#.
// Output channel (out_valid/out_ready, action/position/char_code): zero or one
// transfer per input tick. action 0 writes char_code at position; action 1 is
// a backspace that writes a blank at position (the new cursor).
// cfg_write/cfg_data load the tap window length in ticks; write it only while
// no tick is in flight.
//
// Latency: a result is presented the cycle after the tick that caused it.
// Throughput: one tick per cycle. The keypad state machine and the window
// compare sit between the tick transfer and the result register, so a tick
// is taken every cycle while the result register is empty or being drained.
// When the receiver stalls with a result pending, in_ready drops until that
// result transfers; key state is held meanwhile.
//
// Reset: phase idle, cursor 0, tap count and window count cleared, window
// length 750 ticks, no result pending.
module multitap_keypad_text_entry (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [12:0] key_lines,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        action,
  output logic [6:0]  position,
  output logic [6:0]  char_code
);

  // keypad state
  logic [2:0]  phase, phase_next;
  logic [3:0]  active_key, active_key_next;
  logic [1:0]  tap_count, tap_count_next;
  logic [15:0] window_count, window_count_next;
  logic [6:0]  cursor, cursor_next;
  logic [15:0] window_len;

  logic        accept;
  logic        act_pressed;
  logic        check_close;
  logic        hit;
  logic [3:0]  sel_key;
  logic [15:0] lines_ext;

  // result of the current tick
  logic        res_valid;
  logic        res_action;
  logic [6:0]  res_position;
  logic [6:0]  res_code;

  // output slot is free when empty or draining this cycle
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign lines_ext   = {3'd0, key_lines};
  assign act_pressed = lines_ext[active_key];

  // first pressed key in scan order, key 1 excluded
  always_comb begin
    hit     = 1'b0;
    sel_key = 4'd0;
    for (int k = mkte_pkg::NUM_KEYS - 1; k >= 1; k--) begin
      if (key_lines[k]) begin
        hit     = 1'b1;
        sel_key = 4'(k);
      end
    end
  end

  always_comb begin
    phase_next        = phase;
    active_key_next   = active_key;
    tap_count_next    = tap_count;
    window_count_next = window_count;
    cursor_next       = cursor;
    check_close       = 1'b0;
    res_valid         = 1'b0;
    res_action        = mkte_pkg::ACT_CHAR;
    res_position      = cursor;
    res_code          = mkte_pkg::char_for(active_key, tap_count);

    unique case (phase)
      mkte_pkg::PH_FIRSTHOLD: begin
        // release tick itself does not count
        if (!act_pressed) begin
          window_count_next = 16'd0;
          phase_next        = mkte_pkg::PH_WINDOW;
        end
      end
      mkte_pkg::PH_WINDOW: begin
        window_count_next = window_count + 16'd1;
        if (act_pressed) begin
          tap_count_next = tap_count + 2'd1;
          phase_next     = mkte_pkg::PH_TAPHOLD;
        end else begin
          check_close = 1'b1;
        end
      end
      mkte_pkg::PH_TAPHOLD: begin
        // held ticks do not count; a tap on the last tick closes on release
        if (!act_pressed) begin
          phase_next  = mkte_pkg::PH_WINDOW;
          check_close = 1'b1;
        end
      end
      mkte_pkg::PH_BACKHOLD: begin
        if (!key_lines[mkte_pkg::KEY_BACK]) begin
          cursor_next  = cursor - 7'd1;
          phase_next   = mkte_pkg::PH_IDLE;
          res_valid    = 1'b1;
          res_action   = mkte_pkg::ACT_BLANK;
          res_position = cursor - 7'd1;
          res_code     = mkte_pkg::BLANK_CODE;
        end
      end
      default: begin
        // idle, and any unused phase code
        phase_next = mkte_pkg::PH_IDLE;
        if (hit) begin
          if (sel_key == mkte_pkg::KEY_BACK) begin
            phase_next = mkte_pkg::PH_BACKHOLD;
          end else begin
            active_key_next   = sel_key;
            tap_count_next    = 2'd0;
            window_count_next = 16'd0;
            phase_next        = mkte_pkg::PH_FIRSTHOLD;
          end
        end
      end
    endcase

    if (check_close && (window_count_next >= window_len)) begin
      res_valid   = 1'b1;
      cursor_next = cursor + 7'd1;
      phase_next  = mkte_pkg::PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= mkte_pkg::PH_IDLE;
      active_key   <= 4'd0;
      tap_count    <= 2'd0;
      window_count <= 16'd0;
      cursor       <= 7'd0;
    end else if (accept) begin
      phase        <= phase_next;
      active_key   <= active_key_next;
      tap_count    <= tap_count_next;
      window_count <= window_count_next;
      cursor       <= cursor_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= mkte_pkg::WINDOW_TICKS_RST;
    end else if (cfg_write) begin
      window_len <= cfg_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      action    <= res_action;
      position  <= res_position;
      char_code <= res_code;
    end
  end

  // a character write advances the cursor by one
  a_char_advances: assert property (@(posedge clk) disable iff (rst)
    accept && res_valid && (res_action == mkte_pkg::ACT_CHAR)
    |=> cursor == $past(cursor) + 7'd1)
    else $error("cursor did not advance after character write");

  // a backspace leaves the cursor on the blank it wrote
  a_blank_cursor: assert property (@(posedge clk) disable iff (rst)
    accept && res_valid && (res_action == mkte_pkg::ACT_BLANK)
    |=> out_valid && (position == cursor))
    else $error("backspace position differs from cursor");

  // every result leaves the block back in idle
  a_result_to_idle: assert property (@(posedge clk) disable iff (rst)
    accept && res_valid |=> phase == mkte_pkg::PH_IDLE)
    else $error("result produced without returning to idle");

  // key state moves only on a tick transfer
  a_hold_state: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(tap_count) && $stable(cursor) && $stable(phase))
    else $error("key state changed without a tick transfer");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

// Multi-tap keypad regression. Each transfer on the input channel is one
// millisecond tick of key lines. A shadow model of the keypad state machine
// runs on every accepted tick and queues the display write that tick should
// cause. A checker pops one queued write per output transfer and compares
// action, position and char_code.
module testbench;

  // Key scan positions the package does not name.
  localparam logic [3:0] KEY_TWO   = 4'd1;
  localparam logic [3:0] KEY_THREE = 4'd2;
  localparam logic [3:0] KEY_FOUR  = 4'd4;
  localparam logic [3:0] KEY_FIVE  = 4'd5;
  localparam logic [3:0] KEY_SIX   = 4'd6;
  localparam logic [3:0] KEY_SEVEN = 4'd7;

  localparam int unsigned IDLE_PCT = 32;
  localparam int unsigned TARGET_RANDOM_TICKS = 200;

  typedef struct packed {
    logic       act;
    logic [6:0] pos;
    logic [6:0] code;
  } display_write_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_write;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [12:0] key_lines;
  logic        out_valid;
  logic        out_ready;
  logic        action;
  logic [6:0]  position;
  logic [6:0]  char_code;

  // Shadow copy of the keypad state and the window register.
  logic [2:0]  ph;
  logic [3:0]  held_key;
  logic [1:0]  taps;
  logic [15:0] win_cnt;
  logic [6:0]  cur_pos;
  logic [15:0] win_len;

  display_write_t pending_writes[$];

  int unsigned errors;
  int unsigned ticks_sent;
  int unsigned in_idle_pct;
  int unsigned out_idle_pct;
  int unsigned rx_hold_left;   // receiver hold-off, counted down by the receiver

  multitap_keypad_text_entry dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .key_lines (key_lines),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .action    (action),
    .position  (position),
    .char_code (char_code)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [12:0] key_bit(input logic [3:0] k);
    return 13'd1 << k;
  endfunction

  // Multi-tap character table. Keys 2..8: three letters, then the digit.
  // Key 9 runs Y, Z, '9', backslash. Star, zero and hash never change.
  function automatic logic [6:0] keypad_char(input logic [3:0] k, input logic [1:0] z);
    logic [7:0] c;
    logic [7:0] letter;
    logic [7:0] digit;
    letter = (k == KEY_TWO) ? "D" : (k == KEY_THREE) ? "G" :
             8'("J" + 8'd3 * ({4'd0, k} - 8'd4));
    digit  = (k < mkte_pkg::KEY_BACK) ? 8'("1" + {4'd0, k}) : 8'("0" + {4'd0, k});
    if (k == mkte_pkg::KEY_STAR) c = "*";
    else if (k == mkte_pkg::KEY_ZERO) c = "0";
    else if (k == mkte_pkg::KEY_HASH) c = "#";
    else if (k == mkte_pkg::KEY_NINE) c = (z == 2'd2) ? "9" : 8'("Y" + {6'd0, z});
    else if (k == mkte_pkg::KEY_ONE || k == mkte_pkg::KEY_BACK ||
             k > mkte_pkg::KEY_HASH) c = 8'd0;
    else c = (z == 2'd3) ? digit : 8'(letter + {6'd0, z});
    return c[6:0];
  endfunction

  // One tick of the keypad machine; queues the write it causes, if any.
  task automatic predict_keypad_tick(input logic [12:0] lines);
    logic close_check;
    logic found;
    close_check = 1'b0;
    found = 1'b0;
    case (ph)
      mkte_pkg::PH_FIRSTHOLD: if (!lines[held_key]) begin
        win_cnt = '0;
        ph = mkte_pkg::PH_WINDOW;
      end
      mkte_pkg::PH_WINDOW: begin
        win_cnt = win_cnt + 16'd1;
        if (lines[held_key]) begin
          taps = taps + 2'd1;
          ph = mkte_pkg::PH_TAPHOLD;
        end else begin
          close_check = 1'b1;
        end
      end
      mkte_pkg::PH_TAPHOLD: if (!lines[held_key]) begin
        // release tick: no count, but the window may already be full
        ph = mkte_pkg::PH_WINDOW;
        close_check = 1'b1;
      end
      mkte_pkg::PH_BACKHOLD: if (!lines[mkte_pkg::KEY_BACK]) begin
        cur_pos = cur_pos - 7'd1;
        ph = mkte_pkg::PH_IDLE;
        pending_writes.push_back(display_write_t'{mkte_pkg::ACT_BLANK, cur_pos,
                                                  mkte_pkg::BLANK_CODE});
      end
      default: begin
        // first pressed key in scan order wins; key 1 does nothing
        ph = mkte_pkg::PH_IDLE;
        for (int k = 0; k < int'(mkte_pkg::NUM_KEYS); k++) begin
          if (!found && k != int'(mkte_pkg::KEY_ONE) && lines[k]) begin
            found = 1'b1;
            if (k == int'(mkte_pkg::KEY_BACK)) begin
              ph = mkte_pkg::PH_BACKHOLD;
            end else begin
              held_key = k[3:0];
              taps = '0;
              win_cnt = '0;
              ph = mkte_pkg::PH_FIRSTHOLD;
            end
          end
        end
      end
    endcase
    if (close_check && win_cnt >= win_len) begin
      pending_writes.push_back(display_write_t'{mkte_pkg::ACT_CHAR, cur_pos,
                                                keypad_char(held_key, taps)});
      cur_pos = cur_pos + 7'd1;
      ph = mkte_pkg::PH_IDLE;
    end
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  // Offer one tick, with random idle cycles ahead of it. Valid stays high
  // after the transfer; the next call or a drain decides what follows.
  task automatic send_tick(input logic [12:0] lines);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    key_lines <= lines;
    do @(posedge clk); while (!in_ready);
    predict_keypad_tick(lines);
    ticks_sent++;
  endtask

  // Sender pause: nothing offered until every queued write has come out.
  task automatic wait_all_written();
    in_valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_window(input logic [15:0] len);
    wait_all_written();
    cfg_write <= 1'b1;
    cfg_data  <= len;
    @(posedge clk);
    cfg_write <= 1'b0;
    win_len = len;
  endtask

  // n taps of key k, one tick pressed and one released each, then enough
  // quiet ticks to close any window.
  task automatic enter_char(input logic [3:0] k, input int n);
    repeat (n) begin
      send_tick(key_bit(k));
      send_tick('0);
    end
    repeat (int'(win_len) + 1) send_tick('0);
  endtask

  // Mostly a well-formed tap sequence on a random key with random holds and
  // gaps (gaps around the window length, so some split into two characters),
  // sometimes with stray keys mixed in; otherwise a short burst of noise.
  task automatic random_word();
    logic [3:0]  k;
    logic [12:0] kb;
    logic [12:0] extra;
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 5)) send_tick(13'($urandom));
    end else begin
      k  = 4'($urandom_range(KEY_TWO, mkte_pkg::KEY_HASH));   // back included, key 1 not
      kb = key_bit(k);
      repeat ($urandom_range(1, 5)) begin
        extra = ($urandom_range(9) == 0) ? 13'($urandom) : '0;
        repeat ($urandom_range(1, 3)) send_tick(kb | extra);
        repeat ($urandom_range(0, int'(win_len)))
          send_tick(($urandom_range(7) == 0) ? (13'($urandom) & ~kb) : '0);
      end
      repeat (int'(win_len) + 1) send_tick('0);
    end
  endtask

  // ---------------------------------------------------------------- tests

  // Window length straight out of reset (750 ticks): a run of quiet ticks
  // must not close it; a short window loaded afterwards closes it.
  task automatic test_reset_window();
    send_tick(key_bit(KEY_TWO));
    send_tick('0);
    repeat (20) send_tick('0);
    set_window(16'd2);
    send_tick('0);
  endtask

  // Backspace holds, then blanks; the second one wraps the cursor to 127 and
  // the next character wraps it back to 0.
  task automatic test_backspace();
    set_window(16'd2);
    repeat (2) begin
      repeat (3) send_tick(key_bit(mkte_pkg::KEY_BACK));
      send_tick('0);
    end
    enter_char(mkte_pkg::KEY_ZERO, 1);
  endtask

  // Every key but 1 and back at every tap count, plus a fifth tap wrapping back to the
  // first letter.
  task automatic test_key_map();
    set_window(16'd4);
    for (int idx = KEY_TWO; idx <= mkte_pkg::KEY_HASH; idx++) begin
      if (idx != int'(mkte_pkg::KEY_BACK)) begin
        for (int n = 1; n <= 4; n++) enter_char(idx[3:0], n);
      end
    end
    enter_char(KEY_TWO, 5);
    enter_char(mkte_pkg::KEY_NINE, 5);
  endtask

  // Several lines at once, key 1 inert, other keys ignored in a window.
  task automatic test_simultaneous_keys();
    set_window(16'd2);
    send_tick(13'h1FFF);
    send_tick(13'h1FFF);
    send_tick('0);
    repeat (3) send_tick('0);
    send_tick(key_bit(mkte_pkg::KEY_ONE));
    send_tick('0);
    send_tick(key_bit(mkte_pkg::KEY_ONE) | key_bit(mkte_pkg::KEY_BACK));
    send_tick('0);
    send_tick(key_bit(KEY_FOUR));
    send_tick('0);
    send_tick(key_bit(KEY_FIVE));
    send_tick('0);
    send_tick('0);
  endtask

  // Tap on the last counted tick of the window, held keys not counting,
  // and a zero-length window acting as one tick.
  task automatic test_window_edges();
    set_window(16'd3);
    send_tick(key_bit(KEY_SIX));
    send_tick('0);                       // release tick, not counted
    send_tick('0);
    send_tick('0);
    repeat (3) send_tick(key_bit(KEY_SIX));  // lands on tick 3, then held
    send_tick('0);                       // written on this release
    set_window(16'd0);
    enter_char(KEY_SEVEN, 1);
    set_window(16'd1);
    enter_char(KEY_THREE, 2);
  endtask

  // Largest window: no early close; a short window then closes it.
  task automatic test_longest_window();
    set_window(16'hFFFF);
    send_tick(key_bit(mkte_pkg::KEY_HASH));
    send_tick('0);
    repeat (30) send_tick('0);
    set_window(16'd1);
    send_tick('0);
  endtask

  // No idling on either side.
  task automatic test_back_to_back();
    set_window(16'd2);
    in_idle_pct  = 0;
    out_idle_pct = 0;
    repeat (15) random_word();
    in_idle_pct  = IDLE_PCT;
    out_idle_pct = IDLE_PCT;
  endtask

  // Receiver holds off while ticks keep coming, so the result register
  // fills and in_ready has to drop.
  task automatic test_output_hold_off();
    set_window(16'd1);
    in_idle_pct = 0;
    rx_hold_left = 300;
    repeat (20) random_word();
    in_idle_pct = IDLE_PCT;
    wait_all_written();
  endtask

  task automatic test_random_entry();
    int unsigned start;
    logic [15:0] len;
    start = ticks_sent;
    while (ticks_sent - start < TARGET_RANDOM_TICKS) begin
      case ($urandom_range(3))
        0:       len = 16'd1;
        1:       len = 16'd2;
        2:       len = 16'($urandom_range(1, 6));
        default: len = 16'($urandom_range(1, 12));
      endcase
      set_window(len);
      repeat ($urandom_range(3, 10)) random_word();
    end
  endtask

  // ---------------------------------------------------------------- receiver

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (rx_hold_left != 0) begin
      out_ready <= 1'b0;
      rx_hold_left = rx_hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // Every output transfer must match the oldest queued write.
  always @(posedge clk) begin : check_writes
    display_write_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_writes.size() == 0) begin
        report_mismatch("write with none pending, position", int'(position), 0);
      end else begin
        want = pending_writes.pop_front();
        if (action !== want.act)
          report_mismatch("action", int'(action), int'(want.act));
        if (position !== want.pos)
          report_mismatch("position", int'(position), int'(want.pos));
        if (char_code !== want.code)
          report_mismatch("char_code", int'(char_code), int'(want.code));
      end
    end
  end

  // ---------------------------------------------------------------- main

  initial begin
    rst          = 1'b1;
    cfg_write    = 1'b0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    key_lines    = '0;
    errors       = 0;
    ticks_sent   = 0;
    rx_hold_left = 0;
    in_idle_pct  = IDLE_PCT;
    out_idle_pct = IDLE_PCT;
    ph           = mkte_pkg::PH_IDLE;
    held_key     = '0;
    taps         = '0;
    win_cnt      = '0;
    cur_pos      = '0;
    win_len      = mkte_pkg::WINDOW_TICKS_RST;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_reset_window();
    test_backspace();
    test_key_map();
    test_simultaneous_keys();
    test_window_edges();
    test_longest_window();
    test_back_to_back();
    test_output_hold_off();
    test_random_entry();

    wait_all_written();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/mkte_pkg.sv
sv/multitap_keypad_text_entry.sv
tb/sv/testbench.sv
